// File: src/meo_pkg.sv
// shared types, widths and command codes of the midpoint ellipse outline unit
package meo_pkg;

	localparam int RADIUS_BITS = 12;
	localparam int COORD_BITS  = 16;
	localparam int DIM_BITS    = 13;
	localparam int COLOR_W     = 32;
	localparam int CFG_IDX_W   = 1;

	localparam int STEP_W  = RADIUS_BITS + 1;
	localparam int SQ_W    = 2 * RADIUS_BITS;
	localparam int SLOPE_W = SQ_W + STEP_W + 3;
	localparam int DEC_W   = 2 * STEP_W + SQ_W + 6;
	localparam int OUT_W   = COORD_BITS + 1;
	localparam int MUL_A_W = SQ_W;
	localparam int MUL_B_W = 2 * STEP_W;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'd1;

	localparam logic MODE_START = 1'b0;
	localparam logic MODE_STEP  = 1'b1;

	localparam logic [2:0] MUL_RX_RX   = 3'd0;
	localparam logic [2:0] MUL_RY_RY   = 3'd1;
	localparam logic [2:0] MUL_RX2_RY  = 3'd2;
	localparam logic [2:0] MUL_X_X1    = 3'd3;
	localparam logic [2:0] MUL_RY2_P   = 3'd4;
	localparam logic [2:0] MUL_YM_YM   = 3'd5;
	localparam logic [2:0] MUL_RX2_P   = 3'd6;
	localparam logic [2:0] MUL_RX2_RY2 = 3'd7;

	localparam logic [3:0] OP_NONE     = 4'd0;
	localparam logic [3:0] OP_CAP_RX2  = 4'd1;
	localparam logic [3:0] OP_CAP_RY2  = 4'd2;
	localparam logic [3:0] OP_INIT_DEC = 4'd3;
	localparam logic [3:0] OP_ITER1    = 4'd4;
	localparam logic [3:0] OP_ITER2    = 4'd5;
	localparam logic [3:0] OP_ACC_LOAD = 4'd6;
	localparam logic [3:0] OP_ACC_ADD  = 4'd7;
	localparam logic [3:0] OP_ACC_SUB  = 4'd8;
	localparam logic [3:0] OP_DEC2     = 4'd9;
	localparam logic [3:0] OP_DEACT    = 4'd10;

	typedef logic signed [DEC_W-1:0] dec_t;

	typedef struct packed {
		logic       load;
		logic       emit;
		logic [2:0] mul_sel;
		logic [3:0] op;
	} cmd_t;

	typedef struct packed {
		logic active;
		logic region_two;
		logic slope_lt;
		logic y_pos;
		logic out_free;
	} stat_t;

	// n / 4 rounded half away from zero
	function automatic dec_t round_quarter(input dec_t n);
		dec_t m;
		m = -n;
		if (n >= 0) begin
			return (n + dec_t'(2)) >>> 2;
		end
		return -((m + dec_t'(2)) >>> 2);
	endfunction

endpackage

// File: src/meo_ctrl.sv
// sequencer for start, step and region change of the ellipse rasterizer
module meo_ctrl import meo_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  logic  mode,
	input  stat_t stat,
	output cmd_t  cmd
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SQX  = 4'd1;
	localparam logic [3:0] S_SQY  = 4'd2;
	localparam logic [3:0] S_SPY  = 4'd3;
	localparam logic [3:0] S_DEC0 = 4'd4;
	localparam logic [3:0] S_STEP = 4'd5;
	localparam logic [3:0] S_T1   = 4'd6;
	localparam logic [3:0] S_T2   = 4'd7;
	localparam logic [3:0] S_T3   = 4'd8;
	localparam logic [3:0] S_T4   = 4'd9;
	localparam logic [3:0] S_T5   = 4'd10;
	localparam logic [3:0] S_DEC2 = 4'd11;
	localparam logic [3:0] S_EMIT = 4'd12;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       take;

	assign in_ready = (state_q == S_IDLE) || ((state_q == S_EMIT) && stat.out_free);
	assign take     = in_valid && in_ready;

	always_comb begin
		state_d     = state_q;
		cmd.load    = 1'b0;
		cmd.emit    = 1'b0;
		cmd.mul_sel = MUL_RX_RX;
		cmd.op      = OP_NONE;
		unique case (state_q)
			S_IDLE, S_EMIT: begin
				if (state_q == S_EMIT) begin
					cmd.emit = stat.out_free;
				end
				if (take) begin
					cmd.load = (mode == MODE_START);
					state_d  = (mode == MODE_START) ? S_SQX : S_STEP;
				end else if (state_q == S_EMIT && stat.out_free) begin
					state_d = S_IDLE;
				end
			end
			S_SQX: begin
				cmd.mul_sel = MUL_RX_RX;
				state_d     = S_SQY;
			end
			S_SQY: begin
				cmd.mul_sel = MUL_RY_RY;
				cmd.op      = OP_CAP_RX2;
				state_d     = S_SPY;
			end
			S_SPY: begin
				cmd.mul_sel = MUL_RX2_RY;
				cmd.op      = OP_CAP_RY2;
				state_d     = S_DEC0;
			end
			S_DEC0: begin
				cmd.op  = OP_INIT_DEC;
				state_d = S_EMIT;
			end
			S_STEP: begin
				priority if (!stat.active) begin
					state_d = S_IDLE;
				end else if (!stat.region_two && stat.slope_lt) begin
					cmd.op  = OP_ITER1;
					state_d = S_EMIT;
				end else if (!stat.region_two) begin
					cmd.mul_sel = MUL_X_X1;
					state_d     = S_T1;
				end else if (!stat.y_pos) begin
					cmd.op  = OP_DEACT;
					state_d = S_IDLE;
				end else begin
					cmd.op  = OP_ITER2;
					state_d = S_EMIT;
				end
			end
			S_T1: begin
				cmd.mul_sel = MUL_RY2_P;
				state_d     = S_T2;
			end
			S_T2: begin
				cmd.op      = OP_ACC_LOAD;
				cmd.mul_sel = MUL_YM_YM;
				state_d     = S_T3;
			end
			S_T3: begin
				cmd.mul_sel = MUL_RX2_P;
				state_d     = S_T4;
			end
			S_T4: begin
				cmd.op      = OP_ACC_ADD;
				cmd.mul_sel = MUL_RX2_RY2;
				state_d     = S_T5;
			end
			S_T5: begin
				cmd.op  = OP_ACC_SUB;
				state_d = S_DEC2;
			end
			S_DEC2: begin
				cmd.op  = OP_DEC2;
				state_d = S_STEP;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_start_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(take && mode == MODE_START) |=> (state_q == S_SQX))
		else $error("start item did not enter the squaring sequence");

endmodule

// File: src/meo_datapath.sv
// ellipse state registers, shared multiplier, decision update and output register
module meo_datapath import meo_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cmd_t                        cmd,
	output stat_t                       stat,
	input  logic signed [COORD_BITS-1:0] center_x,
	input  logic signed [COORD_BITS-1:0] center_y,
	input  logic [RADIUS_BITS-1:0]      radius_x,
	input  logic [RADIUS_BITS-1:0]      radius_y,
	input  logic [COLOR_W-1:0]          color,
	input  logic                        cfg_we,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [DIM_BITS-1:0]         cfg_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [OUT_W-1:0]     x_right,
	output logic signed [OUT_W-1:0]     x_left,
	output logic signed [OUT_W-1:0]     y_lower,
	output logic signed [OUT_W-1:0]     y_upper,
	output logic [3:0]                  inside_mask,
	output logic [COLOR_W-1:0]          pixel_color,
	output logic                        last
);

	logic [DIM_BITS-1:0]    width_q, height_q;
	logic                   active_q, region_two_q, out_valid_q;
	logic signed [COORD_BITS-1:0] cx_q, cy_q;
	logic [COLOR_W-1:0]     color_q;
	logic [RADIUS_BITS-1:0] rx_q, ry_q, y_q;
	logic [STEP_W-1:0]      x_q;
	logic [SQ_W-1:0]        rx2_q, ry2_q;
	logic [SLOPE_W-1:0]     spx_q, spy_q;
	dec_t                   dec_q, acc_q;
	logic [PROD_W-1:0]      prod_q;

	logic [MUL_A_W-1:0]     mul_a;
	logic [MUL_B_W-1:0]     mul_b;
	logic [RADIUS_BITS-1:0] ym;
	logic [SLOPE_W-1:0]     spx_up, spy_dn;
	dec_t                   rx2_d, ry2_d, prod4_d, spx_up_d, spy_dn_d;
	logic [STEP_W-1:0]      x_d;
	logic [RADIUS_BITS-1:0] y_d;
	logic [SLOPE_W-1:0]     spx_d, spy_d;
	dec_t                   dec_d, acc_d;
	logic signed [OUT_W-1:0] xr, xl, yl, yu;
	logic                   out_free;

	logic signed [OUT_W-1:0] xr_q, xl_q, yl_q, yu_q;
	logic [3:0]             mask_q;
	logic [COLOR_W-1:0]     pix_q;
	logic                   last_q;

	function automatic logic in_frame(input logic signed [OUT_W-1:0] px,
		input logic signed [OUT_W-1:0] py, input logic [DIM_BITS-1:0] w,
		input logic [DIM_BITS-1:0] h);
		return !px[OUT_W-1] && !py[OUT_W-1]
			&& (px[OUT_W-2:0] < (OUT_W-1)'(w)) && (py[OUT_W-2:0] < (OUT_W-1)'(h));
	endfunction

	assign ym       = y_q - 1'b1;
	assign out_free = !out_valid_q || out_ready;

	assign stat.active     = active_q;
	assign stat.region_two = region_two_q;
	assign stat.slope_lt   = spx_q < spy_q;
	assign stat.y_pos      = (y_q != '0);
	assign stat.out_free   = out_free;

	always_comb begin
		unique case (cmd.mul_sel)
			MUL_RX_RX: begin
				mul_a = MUL_A_W'(rx_q);
				mul_b = MUL_B_W'(rx_q);
			end
			MUL_RY_RY: begin
				mul_a = MUL_A_W'(ry_q);
				mul_b = MUL_B_W'(ry_q);
			end
			MUL_RX2_RY: begin
				mul_a = rx2_q;
				mul_b = MUL_B_W'(ry_q);
			end
			MUL_X_X1: begin
				mul_a = MUL_A_W'(x_q);
				mul_b = MUL_B_W'(x_q) + 1'b1;
			end
			MUL_RY2_P: begin
				mul_a = ry2_q;
				mul_b = prod_q[MUL_B_W-1:0];
			end
			MUL_YM_YM: begin
				mul_a = MUL_A_W'(ym);
				mul_b = MUL_B_W'(ym);
			end
			MUL_RX2_P: begin
				mul_a = rx2_q;
				mul_b = prod_q[MUL_B_W-1:0];
			end
			MUL_RX2_RY2: begin
				mul_a = rx2_q;
				mul_b = MUL_B_W'(ry2_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		rx2_d    = dec_t'(rx2_q);
		ry2_d    = dec_t'(ry2_q);
		prod4_d  = dec_t'(prod_q) <<< 2;
		spx_up   = spx_q + SLOPE_W'({ry2_q, 1'b0});
		spy_dn   = spy_q - SLOPE_W'({rx2_q, 1'b0});
		spx_up_d = dec_t'(spx_up);
		spy_dn_d = dec_t'(spy_dn);
		x_d      = x_q;
		y_d      = y_q;
		spx_d    = spx_q;
		spy_d    = spy_q;
		dec_d    = dec_q;
		acc_d    = acc_q;
		unique case (cmd.op)
			OP_INIT_DEC: begin
				spy_d = SLOPE_W'({prod_q, 1'b0});
				dec_d = round_quarter((ry2_d <<< 2) - prod4_d + rx2_d);
			end
			OP_ITER1: begin
				x_d   = x_q + 1'b1;
				spx_d = spx_up;
				if (dec_q < 0) begin
					dec_d = dec_q + ry2_d + spx_up_d;
				end else begin
					y_d   = y_q - 1'b1;
					spy_d = spy_dn;
					dec_d = dec_q + ry2_d + spx_up_d - spy_dn_d;
				end
			end
			OP_ITER2: begin
				y_d   = y_q - 1'b1;
				spy_d = spy_dn;
				if (dec_q > 0) begin
					dec_d = dec_q + rx2_d - spy_dn_d;
				end else begin
					x_d   = x_q + 1'b1;
					spx_d = spx_up;
					dec_d = dec_q + rx2_d - spy_dn_d + spx_up_d;
				end
			end
			OP_ACC_LOAD: acc_d = prod4_d + ry2_d;
			OP_ACC_ADD:  acc_d = acc_q + prod4_d;
			OP_ACC_SUB:  acc_d = acc_q - prod4_d;
			OP_DEC2:     dec_d = round_quarter(acc_q);
			default: begin
			end
		endcase
	end

	assign xr = {cx_q[COORD_BITS-1], cx_q} + $signed(OUT_W'(x_q));
	assign xl = {cx_q[COORD_BITS-1], cx_q} - $signed(OUT_W'(x_q));
	assign yl = {cy_q[COORD_BITS-1], cy_q} + $signed(OUT_W'(y_q));
	assign yu = {cy_q[COORD_BITS-1], cy_q} - $signed(OUT_W'(y_q));

	// control state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q      <= DIM_BITS'(1024);
			height_q     <= DIM_BITS'(1024);
			active_q     <= 1'b0;
			region_two_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_WIDTH:  width_q  <= cfg_data;
					CFG_HEIGHT: height_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (cmd.load) begin
				active_q     <= 1'b1;
				region_two_q <= 1'b0;
			end else if (cmd.op == OP_DEACT || (cmd.emit && y_q == '0)) begin
				active_q <= 1'b0;
			end
			if (cmd.op == OP_DEC2) begin
				region_two_q <= 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ellipse payload state
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		dec_q  <= dec_d;
		acc_q  <= acc_d;
		spy_q  <= spy_d;
		if (cmd.load) begin
			cx_q    <= center_x;
			cy_q    <= center_y;
			color_q <= color;
			rx_q    <= radius_x;
			ry_q    <= radius_y;
			x_q     <= '0;
			y_q     <= radius_y;
			spx_q   <= '0;
		end else begin
			x_q   <= x_d;
			y_q   <= y_d;
			spx_q <= spx_d;
		end
		if (cmd.op == OP_CAP_RX2) begin
			rx2_q <= prod_q[SQ_W-1:0];
		end
		if (cmd.op == OP_CAP_RY2) begin
			ry2_q <= prod_q[SQ_W-1:0];
		end
		if (cmd.emit) begin
			xr_q   <= xr;
			xl_q   <= xl;
			yl_q   <= yl;
			yu_q   <= yu;
			mask_q <= {in_frame(xl, yu, width_q, height_q), in_frame(xr, yu, width_q, height_q),
				in_frame(xl, yl, width_q, height_q), in_frame(xr, yl, width_q, height_q)};
			pix_q  <= color_q;
			last_q <= (y_q == '0);
		end
	end

	assign out_valid   = out_valid_q;
	assign x_right     = xr_q;
	assign x_left      = xl_q;
	assign y_lower     = yl_q;
	assign y_upper     = yu_q;
	assign inside_mask = mask_q;
	assign pixel_color = pix_q;
	assign last        = last_q;

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> out_free)
		else $error("point set written over an item not yet taken");

	a_last_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && y_q == '0 && !cmd.load) |=> !active_q)
		else $error("ellipse still active after its last point set");

	a_region2_y: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_ITER2 && !cmd.load) |=> (y_q == RADIUS_BITS'($past(y_q) - 1'b1)))
		else $error("region two iteration did not lower y");

endmodule

// File: src/midpoint_ellipse_outline_unit.sv
// top level of the midpoint ellipse outline rasterizer
//
//  port group  direction  handshake              contents
//  in          input      in_valid / in_ready    mode, center, radii, color
//  out         output     out_valid / out_ready  four points, inside mask, color, last
//  cfg         input      cfg_we                 image_width (0), image_height (1)
//
// the start and the step that crosses into region two both go through the one
// shared multiplier
// the next item is taken in the same cycle a point set is loaded into the output register
// out_ready low holds the finished item and stops the block only when a new one is due
// reset clears the sequencer, the active flag and the output valid; sizes return to 1024
module midpoint_ellipse_outline_unit import meo_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         mode,
	input  logic signed [COORD_BITS-1:0] center_x,
	input  logic signed [COORD_BITS-1:0] center_y,
	input  logic [RADIUS_BITS-1:0]       radius_x,
	input  logic [RADIUS_BITS-1:0]       radius_y,
	input  logic [COLOR_W-1:0]           color,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [OUT_W-1:0]      x_right,
	output logic signed [OUT_W-1:0]      x_left,
	output logic signed [OUT_W-1:0]      y_lower,
	output logic signed [OUT_W-1:0]      y_upper,
	output logic [3:0]                   inside_mask,
	output logic [COLOR_W-1:0]           pixel_color,
	output logic                         last,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [DIM_BITS-1:0]          cfg_data
);

	cmd_t  cmd;
	stat_t stat;

	meo_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.mode     (mode),
		.stat     (stat),
		.cmd      (cmd)
	);

	meo_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.center_x    (center_x),
		.center_y    (center_y),
		.radius_x    (radius_x),
		.radius_y    (radius_y),
		.color       (color),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.x_right     (x_right),
		.x_left      (x_left),
		.y_lower     (y_lower),
		.y_upper     (y_upper),
		.inside_mask (inside_mask),
		.pixel_color (pixel_color),
		.last        (last)
	);

endmodule
